// File: design/rvtmr_pkg.sv
// rvtmr_pkg: shared types and constants for the RV32I execute block with TMR register file.
// No dependencies.
package rvtmr_pkg;

  localparam int unsigned NCOPY   = 3;
  localparam int unsigned NREG    = 32;
  localparam int unsigned NCFG    = 8;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned CFG_DW  = 4;

  localparam logic [1:0] REQ_INSTR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_FAULT = 2'd2;

  localparam logic [6:0] OPC_R      = 7'h33;
  localparam logic [6:0] OPC_IALU   = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_LOAD  = 2'd1;
  localparam logic [1:0] MOP_STORE = 2'd2;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_EBREAK  = 2'd1;
  localparam logic [1:0] CAUSE_ECALL   = 2'd2;
  localparam logic [1:0] CAUSE_ILLEGAL = 2'd3;

  localparam logic [2:0] CFG_ALU    = 3'd0;
  localparam logic [2:0] CFG_LOAD   = 3'd1;
  localparam logic [2:0] CFG_STORE  = 3'd2;
  localparam logic [2:0] CFG_BRANCH = 3'd3;
  localparam logic [2:0] CFG_JAL    = 3'd4;
  localparam logic [2:0] CFG_JALR   = 3'd5;
  localparam logic [2:0] CFG_UPPER  = 3'd6;
  localparam logic [2:0] CFG_VOTE   = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] instr_word;
    logic [31:0] load_value;
    logic [1:0]  fault_copy;
    logic [4:0]  fault_reg;
    logic [31:0] fault_mask;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] store_value;
    logic        is_halted;
    logic [1:0]  halt_cause;
    logic [31:0] vote_fixes;
    logic [31:0] retired;
    logic [31:0] cycle_total;
  } out_item_t;

  // Register file write request
  typedef struct packed {
    logic        en;
    logic [2:0]  copies;
    logic [4:0]  addr;
    logic [31:0] data;
    logic        clr_x0;
  } rf_wr_t;

  // Register file read request
  typedef struct packed {
    logic       en;
    logic [4:0] addr_a;
    logic [4:0] addr_b;
  } rf_rd_t;

endpackage

// File: design/rvtmr_if.sv
// rvtmr_in_if / rvtmr_out_if: valid/ready channels of the execute block.
// No dependencies.
interface rvtmr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] instr_word;
  logic [31:0] load_value;
  logic [1:0]  fault_copy;
  logic [4:0]  fault_reg;
  logic [31:0] fault_mask;
  modport source(output valid, req_type, instr_word, load_value, fault_copy, fault_reg,
                 fault_mask, input ready);
  modport sink(input valid, req_type, instr_word, load_value, fault_copy, fault_reg,
               fault_mask, output ready);
endinterface

interface rvtmr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  mem_op;
  logic [31:0] mem_addr;
  logic [1:0]  mem_size;
  logic [31:0] store_value;
  logic        is_halted;
  logic [1:0]  halt_cause;
  logic [31:0] vote_fixes;
  logic [31:0] retired;
  logic [31:0] cycle_total;
  modport source(output valid, next_pc, mem_op, mem_addr, mem_size, store_value, is_halted,
                 halt_cause, vote_fixes, retired, cycle_total, input ready);
  modport sink(input valid, next_pc, mem_op, mem_addr, mem_size, store_value, is_halted,
               halt_cause, vote_fixes, retired, cycle_total, output ready);
endinterface

// File: design/rvtmr_front.sv
// rvtmr_front: two-entry transaction queue between the input channel and the back end.
// Depends on rvtmr_pkg.
module rvtmr_front import rvtmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  item_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      nonempty_o,
  output in_item_t  head_o
);

  in_item_t   ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o    = (cnt_q != 2'd2);
  assign nonempty_o = (cnt_q != 2'd0);
  assign head_o     = ent_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/rvtmr_regfile.sv
// rvtmr_regfile: three register file copies, two registered read ports each, shared write.
// Depends on rvtmr_pkg.
module rvtmr_regfile import rvtmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rf_rd_t            rd_i,
  input  rf_wr_t            wr_i,
  output logic [2:0][31:0]  rda_o,
  output logic [2:0][31:0]  rdb_o
);

  logic [31:0]      mem [NCOPY][NREG];
  logic [2:0][31:0] vld_q;
  logic [2:0][31:0] x0_q;
  logic [2:0][31:0] mema_q, memb_q, x0a_q, x0b_q;
  logic [2:0]       usea_q, useb_q, isx0a_q, isx0b_q;

  // x0 lives in flops; an entry never written reads as zero
  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    always_ff @(posedge clk_i) begin
      if (wr_i.en && wr_i.copies[c] && (wr_i.addr != 5'd0)) begin
        mem[c][wr_i.addr] <= wr_i.data;
      end
      if (rd_i.en) begin
        mema_q[c] <= mem[c][rd_i.addr_a];
        memb_q[c] <= mem[c][rd_i.addr_b];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[c]   <= '0;
        x0_q[c]    <= '0;
        usea_q[c]  <= 1'b0;
        useb_q[c]  <= 1'b0;
        isx0a_q[c] <= 1'b0;
        isx0b_q[c] <= 1'b0;
        x0a_q[c]   <= '0;
        x0b_q[c]   <= '0;
      end else begin
        if (wr_i.en && wr_i.copies[c] && (wr_i.addr != 5'd0)) begin
          vld_q[c][wr_i.addr] <= 1'b1;
        end
        if (wr_i.clr_x0) begin
          x0_q[c] <= '0;
        end else if (wr_i.en && wr_i.copies[c] && (wr_i.addr == 5'd0)) begin
          x0_q[c] <= wr_i.data;
        end
        if (rd_i.en) begin
          usea_q[c]  <= vld_q[c][rd_i.addr_a];
          useb_q[c]  <= vld_q[c][rd_i.addr_b];
          isx0a_q[c] <= (rd_i.addr_a == 5'd0);
          isx0b_q[c] <= (rd_i.addr_b == 5'd0);
          x0a_q[c]   <= x0_q[c];
          x0b_q[c]   <= x0_q[c];
        end
      end
    end

    assign rda_o[c] = isx0a_q[c] ? x0a_q[c] : (usea_q[c] ? mema_q[c] : '0);
    assign rdb_o[c] = isx0b_q[c] ? x0b_q[c] : (useb_q[c] ? memb_q[c] : '0);
  end

endmodule

// File: design/rvtmr_back.sv
// rvtmr_back: execute sequencer, voting, architectural state and the output register.
// Depends on rvtmr_pkg and rvtmr_regfile.
module rvtmr_back import rvtmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              nonempty_i,
  input  in_item_t          head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_o
);

  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e           state_q, state_d;
  in_item_t         cur_q;
  logic [CFG_DW-1:0] cfg_q [NCFG];
  logic [31:0]      pc_q, pc_d, fix_q, fix_d, ret_q, ret_d, cyc_q, cyc_d;
  logic             halted_q, halted_d, ldw_q, ldw_d;
  logic [1:0]       cause_q, cause_d;
  logic [4:0]       ldd_q, ldd_d;
  logic [2:0]       ldk_q, ldk_d;
  logic             out_vld_q;
  out_item_t        out_q, res;

  rf_rd_t           rd;
  rf_wr_t           wr;
  logic [2:0][31:0] rda, rdb;

  logic        exec_go, do_instr;
  logic [31:0] a, b, w, imm_i, imm_s, imm_b, imm_j, op2, alu_r, pc4, ldv;
  logic [6:0]  op;
  logic [4:0]  rdi;
  logic [2:0]  f3;
  logic        alt, dis_a, dis_b, tk;
  logic [3:0]  cost;

  rvtmr_regfile u_rf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rd_i  (rd),
    .wr_i  (wr),
    .rda_o (rda),
    .rdb_o (rdb)
  );

  assign pop_o       = (state_q == S_READ) && nonempty_i;
  assign exec_go     = (state_q == S_EXEC) && (!out_vld_q || out_ready_i);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    rd.en     = pop_o;
    rd.addr_a = (head_i.req_type == REQ_FAULT) ? head_i.fault_reg : head_i.instr_word[19:15];
    rd.addr_b = head_i.instr_word[24:20];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_READ:  if (pop_o) state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_READ;
      default: state_d = S_READ;
    endcase
  end

  // Voting and decode
  always_comb begin
    a     = (rda[0] & rda[1]) | (rda[0] & rda[2]) | (rda[1] & rda[2]);
    b     = (rdb[0] & rdb[1]) | (rdb[0] & rdb[2]) | (rdb[1] & rdb[2]);
    dis_a = !((rda[0] == rda[1]) && (rda[1] == rda[2]));
    dis_b = !((rdb[0] == rdb[1]) && (rdb[1] == rdb[2]));
    w     = cur_q.instr_word;
    op    = w[6:0];
    rdi   = w[11:7];
    f3    = w[14:12];
    alt   = w[30];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    op2   = (op == OPC_R) ? b : imm_i;
    pc4   = pc_q + 32'd4;
    case (f3)
      3'd0:    alu_r = ((op == OPC_R) && alt) ? a - op2 : a + op2;
      3'd1:    alu_r = a << op2[4:0];
      3'd2:    alu_r = {31'd0, $signed(a) < $signed(op2)};
      3'd3:    alu_r = {31'd0, a < op2};
      3'd4:    alu_r = a ^ op2;
      3'd5:    alu_r = alt ? 32'($signed(a) >>> op2[4:0]) : a >> op2[4:0];
      3'd6:    alu_r = a | op2;
      default: alu_r = a & op2;
    endcase
    case (ldk_q)
      3'd0:    ldv = {{24{cur_q.load_value[7]}}, cur_q.load_value[7:0]};
      3'd1:    ldv = {{16{cur_q.load_value[15]}}, cur_q.load_value[15:0]};
      3'd4:    ldv = {24'd0, cur_q.load_value[7:0]};
      3'd5:    ldv = {16'd0, cur_q.load_value[15:0]};
      default: ldv = cur_q.load_value;
    endcase
  end

  // Execute
  always_comb begin
    do_instr = (cur_q.req_type == REQ_INSTR) && !halted_q && !ldw_q;
    pc_d     = pc_q;
    halted_d = halted_q;
    cause_d  = cause_q;
    ldw_d    = ldw_q;
    ldd_d    = ldd_q;
    ldk_d    = ldk_q;
    cost     = 4'd1;
    tk       = 1'b0;
    res      = '0;
    wr       = '0;
    wr.copies = 3'b111;

    case (cur_q.req_type)
      REQ_FAULT: begin
        if (cur_q.fault_copy != 2'd3) begin
          wr.en     = 1'b1;
          wr.addr   = cur_q.fault_reg;
          case (cur_q.fault_copy)
            2'd0:    begin wr.copies = 3'b001; wr.data = rda[0] ^ cur_q.fault_mask; end
            2'd1:    begin wr.copies = 3'b010; wr.data = rda[1] ^ cur_q.fault_mask; end
            default: begin wr.copies = 3'b100; wr.data = rda[2] ^ cur_q.fault_mask; end
          endcase
        end
      end
      REQ_LOAD: begin
        if (ldw_q) begin
          wr.en   = (ldd_q != 5'd0);
          wr.addr = ldd_q;
          wr.data = ldv;
          ldw_d   = 1'b0;
        end
      end
      default: ;
    endcase

    if (do_instr) begin
      pc_d       = pc4;
      wr.clr_x0  = 1'b1;
      wr.addr    = rdi;
      case (op)
        OPC_R, OPC_IALU: begin
          cost = cfg_q[CFG_ALU]; wr.en = (rdi != 5'd0); wr.data = alu_r;
        end
        OPC_LOAD: begin
          cost = cfg_q[CFG_LOAD];
          if ((f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7)) begin
            halted_d = 1'b1; cause_d = CAUSE_ILLEGAL;
          end else begin
            res.mem_op   = MOP_LOAD;
            res.mem_addr = a + imm_i;
            res.mem_size = f3[1:0];
            ldw_d = 1'b1; ldd_d = rdi; ldk_d = f3;
          end
        end
        OPC_STORE: begin
          cost = cfg_q[CFG_STORE];
          if (f3 > 3'd2) begin
            halted_d = 1'b1; cause_d = CAUSE_ILLEGAL;
          end else begin
            res.mem_op   = MOP_STORE;
            res.mem_addr = a + imm_s;
            res.mem_size = f3[1:0];
            case (f3)
              3'd0:    res.store_value = {24'd0, b[7:0]};
              3'd1:    res.store_value = {16'd0, b[15:0]};
              default: res.store_value = b;
            endcase
          end
        end
        OPC_BRANCH: begin
          cost = cfg_q[CFG_BRANCH];
          case (f3)
            3'd0:    tk = (a == b);
            3'd1:    tk = (a != b);
            3'd4:    tk = $signed(a) < $signed(b);
            3'd5:    tk = !($signed(a) < $signed(b));
            3'd6:    tk = a < b;
            3'd7:    tk = !(a < b);
            default: begin halted_d = 1'b1; cause_d = CAUSE_ILLEGAL; end
          endcase
          if (tk) pc_d = pc_q + imm_b;
        end
        OPC_LUI: begin
          cost = cfg_q[CFG_UPPER]; wr.en = (rdi != 5'd0); wr.data = {w[31:12], 12'd0};
        end
        OPC_AUIPC: begin
          cost = cfg_q[CFG_UPPER]; wr.en = (rdi != 5'd0); wr.data = pc_q + {w[31:12], 12'd0};
        end
        OPC_JAL: begin
          cost = cfg_q[CFG_JAL]; pc_d = pc_q + imm_j; wr.en = (rdi != 5'd0); wr.data = pc4;
        end
        OPC_JALR: begin
          cost = cfg_q[CFG_JALR]; pc_d = (a + imm_i) & ~32'd1;
          wr.en = (rdi != 5'd0); wr.data = pc4;
        end
        OPC_SYSTEM: begin
          halted_d = 1'b1; cause_d = (w == EBREAK_WORD) ? CAUSE_EBREAK : CAUSE_ECALL;
        end
        default: begin
          halted_d = 1'b1; cause_d = CAUSE_ILLEGAL;
        end
      endcase
    end

    fix_d = fix_q + (do_instr ? {30'd0, 2'({1'b0, dis_a} + {1'b0, dis_b})} : 32'd0);
    ret_d = ret_q + {31'd0, do_instr};
    cyc_d = cyc_q + (do_instr ? {27'd0, {1'b0, cost} + {1'b0, cfg_q[CFG_VOTE]}} : 32'd0);
    wr.en     = wr.en && exec_go;
    wr.clr_x0 = wr.clr_x0 && exec_go;

    res.next_pc     = pc_d;
    res.is_halted   = halted_d;
    res.halt_cause  = cause_d;
    res.vote_fixes  = fix_d;
    res.retired     = ret_d;
    res.cycle_total = cyc_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (exec_go) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_READ;
      pc_q      <= '0;
      halted_q  <= 1'b0;
      cause_q   <= CAUSE_NONE;
      ldw_q     <= 1'b0;
      ldd_q     <= '0;
      ldk_q     <= '0;
      fix_q     <= '0;
      ret_q     <= '0;
      cyc_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NCFG; i++) begin
        cfg_q[i] <= (i == int'(CFG_VOTE)) ? 4'd0 : 4'd1;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
      if (exec_go) begin
        pc_q     <= pc_d;
        halted_q <= halted_d;
        cause_q  <= cause_d;
        ldw_q    <= ldw_d;
        ldd_q    <= ldd_d;
        ldk_q    <= ldk_d;
        fix_q    <= fix_d;
        ret_q    <= ret_d;
        cyc_q    <= cyc_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt flag cleared");

  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && do_instr && (res.mem_op == MOP_LOAD)) |=> ldw_q)
    else $error("load issued without pending flag");

  a_retire_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ret_q != $past(ret_q)) |-> (ret_q == $past(ret_q) + 32'd1))
    else $error("retired count jumped");

  a_no_pop_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !pop_o) else $error("queue popped during execute");

endmodule

// File: design/rv32i_execute_tmr_regfile.sv
// rv32i_execute_tmr_regfile: top level, RV32I execute with a triple-voted register file.
// Depends on rvtmr_pkg, rvtmr_if, rvtmr_front, rvtmr_back.
// Flow: a transaction accepted into the queue is popped and its operands read in the
// read state, and its result is registered when execute completes.
// The back end pops no new transaction while one executes: the registered read of the
// register file memories is followed by execute/write-back. A held result stalls execute.
// Reset: asynchronous; clears PC, counters, halt/load state, queue, register file valid bits.
module rv32i_execute_tmr_regfile import rvtmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  rvtmr_in_if.sink          req_i,
  rvtmr_out_if.source       rsp_o
);

  in_item_t  in_item, head;
  out_item_t out_item;
  logic      push, pop, nonempty, q_ready;

  // Front: input transactions land in a two-entry queue, so the channel can accept up to
  // two of them while the back end works or waits on a full result register.
  always_comb begin
    in_item.req_type   = req_i.req_type;
    in_item.instr_word = req_i.instr_word;
    in_item.load_value = req_i.load_value;
    in_item.fault_copy = req_i.fault_copy;
    in_item.fault_reg  = req_i.fault_reg;
    in_item.fault_mask = req_i.fault_mask;
  end

  assign req_i.ready = q_ready;
  assign push        = req_i.valid && q_ready;

  rvtmr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (in_item),
    .ready_o   (q_ready),
    .pop_i     (pop),
    .nonempty_o(nonempty),
    .head_o    (head)
  );

  // Back: read the three copies, vote, execute, write back, and register
  // one result per transaction.
  rvtmr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .nonempty_i (nonempty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .out_o      (out_item)
  );

  assign rsp_o.next_pc     = out_item.next_pc;
  assign rsp_o.mem_op      = out_item.mem_op;
  assign rsp_o.mem_addr    = out_item.mem_addr;
  assign rsp_o.mem_size    = out_item.mem_size;
  assign rsp_o.store_value = out_item.store_value;
  assign rsp_o.is_halted   = out_item.is_halted;
  assign rsp_o.halt_cause  = out_item.halt_cause;
  assign rsp_o.vote_fixes  = out_item.vote_fixes;
  assign rsp_o.retired     = out_item.retired;
  assign rsp_o.cycle_total = out_item.cycle_total;

endmodule
